// ===== hdl/fpr_pkg.sv =====
package fpr_pkg;

    localparam int SESSIONS  = 8;
    localparam int SLOT_W    = $clog2(SESSIONS);
    localparam int WORDS     = 32;
    localparam int WIDX_W    = $clog2(WORDS);
    localparam int MEM_DEPTH = SESSIONS * WORDS;
    localparam int MADDR_W   = SLOT_W + WIDX_W;

    localparam logic [31:0] TIMEOUT_RESET = 32'd750;
    localparam logic [4:0]  FC_MASK       = 5'h1F;
    localparam logic [2:0]  SEQ_MASK      = 3'h7;

    typedef logic [63:0] t_word;

    // One access to the byte store: one write port, one read port.
    typedef struct packed {
        logic               we;
        logic [MADDR_W-1:0] waddr;
        t_word              wdata;
        logic [MADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== hdl/fpr_store.sv =====
module fpr_store (
    input  logic              i_clk,
    input  fpr_pkg::t_mem_req i_req,
    output fpr_pkg::t_word    o_rd_data
);

    fpr_pkg::t_word r_mem [fpr_pkg::MEM_DEPTH];
    fpr_pkg::t_word r_rd_data;

    // write port, registered read port; a read of the word being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/fast_packet_reassembler.sv =====
// Fast-packet reassembler. Issue one frame or one time tick per start pulse while busy is
// low; a tick takes effect at once and never raises busy. Message bytes live in a 256 x
// 64-bit store with one write and one read port, eight bytes per word, 32 words per
// session; session headers sit in flops. Opening a session writes the first frame's bytes
// to its word 0 and clears its other 31 store words, one a cycle, then sweeps for expiry.
// A later frame does a read-modify-write of up to two store words, streams out the message
// if that frame completes it, then sweeps for expiry. A completed message streams out one
// word per cycle through the store's read register and the output register; a single-frame
// message appears on the output the cycle after it is taken. Each word is shown for exactly
// one cycle on o_word_valid: the receiver cannot stall, so take every word as it comes.
module fast_packet_reassembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_source_addr,
    input  logic [17:0] i_pgn,
    input  logic [7:0]  i_dest_addr,
    input  logic        i_to_all,
    input  logic [3:0]  i_frame_len,
    input  logic [63:0] i_frame_data,
    // result words
    output logic        o_word_valid,
    output logic [17:0] o_msg_pgn,
    output logic [7:0]  o_msg_source,
    output logic [7:0]  o_msg_dest,
    output logic [7:0]  o_msg_length,
    output logic [4:0]  o_word_index,
    output logic [63:0] o_word_data,
    output logic        o_last_word,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLR   = 3'd1;
    localparam logic [2:0] ST_RD0   = 3'd2;
    localparam logic [2:0] ST_MG0   = 3'd3;
    localparam logic [2:0] ST_RD1   = 3'd4;
    localparam logic [2:0] ST_MG1   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_SWEEP = 3'd7;

    localparam logic REG_TIMEOUT = 1'b0;

    // control state
    logic [2:0]  r_state;
    logic [31:0] r_timeout;
    logic [31:0] r_time;
    logic [fpr_pkg::SESSIONS-1:0] r_valid;

    // session headers
    logic [7:0]  r_s_source [fpr_pkg::SESSIONS];
    logic [17:0] r_s_pgn    [fpr_pkg::SESSIONS];
    logic [7:0]  r_s_dest   [fpr_pkg::SESSIONS];
    logic [2:0]  r_s_seq    [fpr_pkg::SESSIONS];
    logic [7:0]  r_s_total  [fpr_pkg::SESSIONS];
    logic [5:0]  r_s_next   [fpr_pkg::SESSIONS];
    logic [31:0] r_s_seen   [fpr_pkg::SESSIONS];

    // working registers for the item in hand
    logic [fpr_pkg::SLOT_W-1:0] r_slot;
    logic [fpr_pkg::WIDX_W-1:0] r_wcnt;
    logic [fpr_pkg::WIDX_W-1:0] r_w0;
    logic [fpr_pkg::WIDX_W-1:0] r_w1;
    logic [fpr_pkg::WIDX_W-1:0] r_last_idx;
    logic [7:0]  r_off;
    logic [2:0]  r_chunk;
    logic        r_done;
    logic [7:0]  r_b [8];
    fpr_pkg::t_word r_first_word;

    // message identity, held for the words of one message
    logic [17:0] r_msg_pgn;
    logic [7:0]  r_msg_source;
    logic [7:0]  r_msg_dest;
    logic [7:0]  r_msg_total;

    // read pipeline and output stage
    logic        r_p_vld;
    logic [fpr_pkg::WIDX_W-1:0] r_p_idx;
    logic        r_p_last;
    logic        r_out_vld;
    logic [fpr_pkg::WIDX_W-1:0] r_out_idx;
    fpr_pkg::t_word r_out_data;
    logic        r_out_last;

    // decode of the incoming frame
    logic        accept;
    logic [7:0]  b [8];
    logic [3:0]  len;
    logic [2:0]  seq;
    logic [4:0]  fc;
    logic [7:0]  dst;
    logic [7:0]  total0;
    logic        hit;
    logic [fpr_pkg::SLOT_W-1:0] hit_slot;
    logic        has_free;
    logic [fpr_pkg::SLOT_W-1:0] free_slot;
    logic [3:0]  lm2;
    logic [2:0]  first;
    logic        single;
    fpr_pkg::t_word first_word;
    logic [4:0]  fcm1;
    logic [7:0]  off;
    logic [7:0]  cur_total;
    logic [7:0]  rem;
    logic [3:0]  avail;
    logic [2:0]  chunk;
    logic [8:0]  end_pos;
    logic        done;
    logic [7:0]  end_byte;

    fpr_pkg::t_mem_req mem_req;
    fpr_pkg::t_word    rd_data;
    fpr_pkg::t_word    merged;
    fpr_pkg::t_word    masked;
    logic              cfg_wr;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? r_timeout : 32'd0;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            b[k] = i_frame_data[8*k +: 8];
        end
        len    = (i_frame_len > 4'd8) ? 4'd8 : i_frame_len;
        seq    = b[0][7:5] & fpr_pkg::SEQ_MASK;
        fc     = b[0][4:0] & fpr_pkg::FC_MASK;
        dst    = i_to_all ? 8'hFF : i_dest_addr;
        total0 = b[1];

        // lowest matching slot, lowest free slot
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int s = fpr_pkg::SESSIONS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_s_source[s] == i_source_addr && r_s_pgn[s] == i_pgn) begin
                hit      = 1'b1;
                hit_slot = fpr_pkg::SLOT_W'(s);
            end
            if (!r_valid[s]) begin
                has_free  = 1'b1;
                free_slot = fpr_pkg::SLOT_W'(s);
            end
        end

        // first frame: up to six payload bytes
        lm2   = len - 4'd2;
        first = (lm2 > 4'd6) ? 3'd6 : lm2[2:0];
        if ({5'd0, first} > total0) begin
            first = total0[2:0];
        end
        single = ({5'd0, first} >= total0);
        for (int p = 0; p < 8; p++) begin
            first_word[8*p +: 8] = (p < 6 && 3'(p) < first) ? b[(p + 2) % 8] : 8'd0;
        end

        // later frame: seven bytes each from offset six on
        fcm1      = fc - 5'd1;
        off       = 8'd6 + ({fcm1, 3'b000} - {3'b000, fcm1});
        cur_total = r_s_total[hit_slot];
        rem       = (off < cur_total) ? cur_total - off : 8'd0;
        avail     = len - 4'd1;
        chunk     = (rem < 8'd7) ? rem[2:0] : 3'd7;
        if ({1'b0, chunk} > avail) begin
            chunk = avail[2:0];
        end
        end_pos  = {1'b0, off} + {6'd0, chunk};
        done     = (end_pos >= {1'b0, cur_total});
        end_byte = off + {5'd0, chunk} - 8'd1;
    end

    // merge the frame's bytes into the word just read
    always_comb begin
        logic [7:0] j;
        logic [8:0] jx;
        logic [2:0] bi;
        logic [fpr_pkg::WIDX_W-1:0] w;
        w = (r_state == ST_MG1) ? r_w1 : r_w0;
        for (int p = 0; p < 8; p++) begin
            j  = {w, 3'(p)};
            jx = {1'b0, j};
            bi = 3'(j - r_off) + 3'd1;
            merged[8*p +: 8] = (j >= r_off && jx < {1'b0, r_off} + {6'd0, r_chunk})
                               ? r_b[bi] : rd_data[8*p +: 8];
        end
    end

    // zero bytes past the message length
    always_comb begin
        for (int p = 0; p < 8; p++) begin
            masked[8*p +: 8] = ({r_p_idx, 3'(p)} < r_msg_total) ? rd_data[8*p +: 8] : 8'd0;
        end
    end

    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.waddr = {r_slot, r_wcnt};
        mem_req.wdata = '0;
        mem_req.raddr = {r_slot, r_w0};
        unique case (r_state)
            ST_CLR: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = (r_wcnt == '0) ? r_first_word : '0;
            end
            ST_MG0: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {r_slot, r_w0};
                mem_req.wdata = merged;
            end
            ST_RD1: begin
                mem_req.raddr = {r_slot, r_w1};
            end
            ST_MG1: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {r_slot, r_w1};
                mem_req.wdata = merged;
            end
            ST_EMIT: begin
                mem_req.raddr = {r_slot, r_wcnt};
            end
            default: begin
            end
        endcase
    end

    fpr_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_timeout <= fpr_pkg::TIMEOUT_RESET;
            r_time    <= '0;
            r_valid   <= '0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_TIMEOUT) begin
                r_timeout <= pwdata;
            end
            r_p_vld   <= 1'b0;
            r_out_vld <= r_p_vld;
            if (r_p_vld) begin
                r_out_idx  <= r_p_idx;
                r_out_data <= masked;
                r_out_last <= r_p_last;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_mode) begin
                        r_time <= r_time + 32'd1;
                    end else if (accept && len != 4'd0) begin
                        for (int k = 0; k < 8; k++) begin
                            r_b[k] <= b[k];
                        end
                        if (fc == 5'd0) begin
                            if (len >= 4'd2 && total0 != 8'd0) begin
                                if (single) begin
                                    // whole message in the first frame: show it now
                                    r_msg_pgn    <= i_pgn;
                                    r_msg_source <= i_source_addr;
                                    r_msg_dest   <= dst;
                                    r_msg_total  <= total0;
                                    r_out_vld    <= 1'b1;
                                    r_out_idx    <= '0;
                                    r_out_data   <= first_word;
                                    r_out_last   <= 1'b1;
                                end else if (hit || has_free) begin
                                    r_slot               <= hit ? hit_slot : free_slot;
                                    r_valid[hit ? hit_slot : free_slot] <= 1'b1;
                                    r_s_source[hit ? hit_slot : free_slot] <= i_source_addr;
                                    r_s_pgn[hit ? hit_slot : free_slot]    <= i_pgn;
                                    r_s_dest[hit ? hit_slot : free_slot]   <= dst;
                                    r_s_seq[hit ? hit_slot : free_slot]    <= seq;
                                    r_s_total[hit ? hit_slot : free_slot]  <= total0;
                                    r_s_next[hit ? hit_slot : free_slot]   <= 6'd1;
                                    r_s_seen[hit ? hit_slot : free_slot]   <= r_time;
                                    r_first_word <= first_word;
                                    r_wcnt       <= '0;
                                    r_state      <= ST_CLR;
                                end else begin
                                    // table full: drop the frame, still sweep
                                    r_state <= ST_SWEEP;
                                end
                            end
                        end else if (hit) begin
                            if (seq != r_s_seq[hit_slot] || {1'b0, fc} != r_s_next[hit_slot]) begin
                                r_valid[hit_slot] <= 1'b0;
                            end else begin
                                r_slot     <= hit_slot;
                                r_off      <= off;
                                r_chunk    <= chunk;
                                r_done     <= done;
                                r_w0       <= off[7:3];
                                r_w1       <= end_byte[7:3];
                                r_wcnt     <= '0;
                                r_last_idx <= 5'((cur_total - 8'd1) >> 3);
                                r_s_next[hit_slot] <= {1'b0, fc} + 6'd1;
                                r_s_seen[hit_slot] <= r_time;
                                r_msg_pgn    <= r_s_pgn[hit_slot];
                                r_msg_source <= r_s_source[hit_slot];
                                r_msg_dest   <= r_s_dest[hit_slot];
                                r_msg_total  <= cur_total;
                                if (done) begin
                                    r_valid[hit_slot] <= 1'b0;
                                end
                                if (chunk != 3'd0) begin
                                    r_state <= ST_RD0;
                                end else begin
                                    r_state <= done ? ST_EMIT : ST_SWEEP;
                                end
                            end
                        end
                    end
                end
                ST_CLR: begin
                    r_wcnt <= r_wcnt + 5'd1;
                    if (r_wcnt == 5'(fpr_pkg::WORDS - 1)) begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_RD0: begin
                    r_state <= ST_MG0;
                end
                ST_MG0: begin
                    if (r_w1 != r_w0) begin
                        r_state <= ST_RD1;
                    end else begin
                        r_state <= r_done ? ST_EMIT : ST_SWEEP;
                    end
                end
                ST_RD1: begin
                    r_state <= ST_MG1;
                end
                ST_MG1: begin
                    r_state <= r_done ? ST_EMIT : ST_SWEEP;
                end
                ST_EMIT: begin
                    r_p_vld  <= 1'b1;
                    r_p_idx  <= r_wcnt;
                    r_p_last <= (r_wcnt == r_last_idx);
                    r_wcnt   <= r_wcnt + 5'd1;
                    if (r_wcnt == r_last_idx) begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    // drop every session idle for longer than the timeout
                    for (int s = 0; s < fpr_pkg::SESSIONS; s++) begin
                        if (r_valid[s] && (r_time - r_s_seen[s]) > r_timeout) begin
                            r_valid[s] <= 1'b0;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_word_valid = r_out_vld;
    assign o_msg_pgn    = r_msg_pgn;
    assign o_msg_source = r_msg_source;
    assign o_msg_dest   = r_msg_dest;
    assign o_msg_length = r_msg_total;
    assign o_word_index = r_out_idx;
    assign o_word_data  = r_out_data;
    assign o_last_word  = r_out_last;

    // words of one message come out back to back
    a_words_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid && !o_last_word |=> o_word_valid)
        else $error("word stream broken inside a message");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid && !o_last_word |=> o_word_index == $past(o_word_index) + 5'd1)
        else $error("word index did not advance");

    a_last_matches_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid && o_last_word |-> o_word_index == 5'((o_msg_length - 8'd1) >> 3))
        else $error("final word index disagrees with message length");

    a_tick_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_mode |=> !busy)
        else $error("time tick raised busy");

endmodule

// ===== tb/fpr_checker.sv =====
`timescale 1ns / 100ps

module fpr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_mode,
    input  logic [7:0]  i_source_addr,
    input  logic [17:0] i_pgn,
    input  logic [7:0]  i_dest_addr,
    input  logic        i_to_all,
    input  logic [3:0]  i_frame_len,
    input  logic [63:0] i_frame_data,
    input  logic        o_word_valid,
    input  logic [17:0] o_msg_pgn,
    input  logic [7:0]  o_msg_source,
    input  logic [7:0]  o_msg_dest,
    input  logic [7:0]  o_msg_length,
    input  logic [4:0]  o_word_index,
    input  logic [63:0] o_word_data,
    input  logic        o_last_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_words_pending
);

    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
    localparam logic       MODE_TICK    = 1'b1;

    typedef struct packed {
        logic [17:0] pgn;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  len;
        logic [4:0]  idx;
        logic [63:0] data;
        logic        last;
    } t_msg_word;

    t_msg_word   msg_words_due[$];
    int          mismatches;

    logic        sess_open   [fpr_pkg::SESSIONS];
    logic [7:0]  sess_src    [fpr_pkg::SESSIONS];
    logic [17:0] sess_pgn    [fpr_pkg::SESSIONS];
    logic [7:0]  sess_dst    [fpr_pkg::SESSIONS];
    logic [2:0]  sess_seq    [fpr_pkg::SESSIONS];
    logic [7:0]  sess_total  [fpr_pkg::SESSIONS];
    logic [5:0]  sess_next   [fpr_pkg::SESSIONS];
    logic [31:0] sess_seen   [fpr_pkg::SESSIONS];
    logic [7:0]  sess_bytes  [fpr_pkg::SESSIONS][256];
    logic        sess_has    [fpr_pkg::SESSIONS][256];
    logic [7:0]  msg_buf     [256];
    logic [31:0] ticks_now;
    logic [31:0] timeout;

    // Queue the words of a finished message held in msg_buf.
    task automatic queue_message(logic [17:0] pgn, logic [7:0] src, logic [7:0] dst,
                                 int total);
        int        nw;
        t_msg_word w;
        nw = (total + 7) / 8;
        for (int i = 0; i < nw; i++) begin
            w.pgn  = pgn;
            w.src  = src;
            w.dst  = dst;
            w.len  = total[7:0];
            w.idx  = i[4:0];
            w.data = '0;
            for (int k = 0; k < 8; k++)
                if (i * 8 + k < total) w.data[8*k +: 8] = msg_buf[i * 8 + k];
            w.last = (i + 1 == nw);
            msg_words_due.push_back(w);
        end
    endtask

    task automatic expire_stale();
        for (int s = 0; s < fpr_pkg::SESSIONS; s++)
            if (sess_open[s] && (ticks_now - sess_seen[s]) > timeout) sess_open[s] = 1'b0;
    endtask

    // Apply one frame to the session table, queueing any finished message.
    task automatic absorb_frame();
        logic [7:0] b [8];
        logic [7:0] dst;
        int         len, seq, fc, slot, total, first, off, rem, chunk;
        dst  = i_to_all ? 8'hFF : i_dest_addr;
        len  = (i_frame_len > 8) ? 8 : int'(i_frame_len);
        if (len == 0) return;
        for (int k = 0; k < 8; k++) b[k] = i_frame_data[8*k +: 8];
        seq  = int'((b[0] >> 5) & fpr_pkg::SEQ_MASK);
        fc   = int'(b[0] & fpr_pkg::FC_MASK);
        slot = fpr_pkg::SESSIONS;
        for (int s = fpr_pkg::SESSIONS - 1; s >= 0; s--)
            if (sess_open[s] && sess_src[s] == i_source_addr && sess_pgn[s] == i_pgn)
                slot = s;
        if (fc == 0) begin
            if (len < 2) return;
            total = int'(b[1]);
            if (total == 0) return;
            first = len - 2;
            if (first > total) first = total;
            if (first >= total) begin
                for (int k = 0; k < 256; k++) msg_buf[k] = (k < first) ? b[2 + k] : 8'h00;
                queue_message(i_pgn, i_source_addr, dst, total);
                return;
            end
            if (slot == fpr_pkg::SESSIONS)
                for (int s = fpr_pkg::SESSIONS - 1; s >= 0; s--)
                    if (!sess_open[s]) slot = s;
            if (slot < fpr_pkg::SESSIONS) begin
                sess_open[slot]  = 1'b1;
                sess_src[slot]   = i_source_addr;
                sess_pgn[slot]   = i_pgn;
                sess_dst[slot]   = dst;
                sess_seq[slot]   = seq[2:0];
                sess_total[slot] = total[7:0];
                sess_next[slot]  = 6'd1;
                sess_seen[slot]  = ticks_now;
                for (int k = 0; k < 256; k++) sess_has[slot][k] = 1'b0;
                for (int k = 0; k < first; k++) begin
                    sess_bytes[slot][k] = b[2 + k];
                    sess_has[slot][k]   = 1'b1;
                end
            end
        end else begin
            if (slot == fpr_pkg::SESSIONS) return;
            if (seq != sess_seq[slot] || fc != sess_next[slot]) begin
                sess_open[slot] = 1'b0;
                return;
            end
            total = int'(sess_total[slot]);
            off   = 6 + (fc - 1) * 7;
            rem   = (off < total) ? total - off : 0;
            chunk = (rem < 7) ? rem : 7;
            if (chunk > len - 1) chunk = len - 1;
            for (int k = 0; k < chunk; k++)
                if (off + k < 256) begin
                    sess_bytes[slot][off + k] = b[1 + k];
                    sess_has[slot][off + k]   = 1'b1;
                end
            sess_next[slot] = 6'(fc + 1);
            sess_seen[slot] = ticks_now;
            if (off + chunk >= total) begin
                for (int k = 0; k < 256; k++)
                    msg_buf[k] = (k < total && sess_has[slot][k]) ? sess_bytes[slot][k] : 8'h00;
                sess_open[slot] = 1'b0;
                queue_message(sess_pgn[slot], sess_src[slot], sess_dst[slot], total);
            end
        end
        expire_stale();
    endtask

    task automatic compare_word();
        t_msg_word got, want;
        got = '{o_msg_pgn, o_msg_source, o_msg_dest, o_msg_length, o_word_index,
                o_word_data, o_last_word};
        if (msg_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected word idx %0d data %h", $realtime, got.idx, got.data);
            return;
        end
        want = msg_words_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] word mismatch: exp pgn %h src %h dst %h len %0d idx %0d data %h last %b",
                         $realtime, want.pgn, want.src, want.dst, want.len, want.idx,
                         want.data, want.last);
                $display("    got pgn %h src %h dst %h len %0d idx %0d data %h last %b",
                         got.pgn, got.src, got.dst, got.len, got.idx, got.data, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fpr_pkg::SESSIONS; s++) begin
                sess_open[s]  = 1'b0;
                sess_src[s]   = '0;
                sess_pgn[s]   = '0;
                sess_dst[s]   = '0;
                sess_seq[s]   = '0;
                sess_total[s] = '0;
                sess_next[s]  = '0;
                sess_seen[s]  = '0;
                for (int k = 0; k < 256; k++) sess_has[s][k] = 1'b0;
            end
            ticks_now = '0;
            timeout   = fpr_pkg::TIMEOUT_RESET;
            msg_words_due.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT) timeout = pwdata;
            if (o_word_valid) compare_word();
            if (start && !busy) begin
                if (i_mode == MODE_TICK) ticks_now = ticks_now + 32'd1;
                else absorb_frame();
            end
        end
        o_fail_count    <= mismatches;
        o_words_pending <= msg_words_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam logic       MODE_FRAME   = 1'b0;
    localparam logic       MODE_TICK    = 1'b1;
    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
    localparam int         SETTLE       = 80;       // longest internal work after the last word
    localparam int         CYCLE_LIMIT  = 800000;
    localparam int         NKEYS        = 11;       // more keys than slots so the table fills

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [7:0]  i_source_addr;
    logic [17:0] i_pgn;
    logic [7:0]  i_dest_addr;
    logic        i_to_all;
    logic [3:0]  i_frame_len;
    logic [63:0] i_frame_data;
    logic        o_word_valid;
    logic [17:0] o_msg_pgn;
    logic [7:0]  o_msg_source;
    logic [7:0]  o_msg_dest;
    logic [7:0]  o_msg_length;
    logic [4:0]  o_word_index;
    logic [63:0] o_word_data;
    logic        o_last_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          words_pending;
    int          items_sent;
    int          cycles;
    bit          quiet;          // no idling while set
    int          tick_odds;      // percent chance of a tick between frames

    logic [7:0]  key_src [NKEYS];
    logic [17:0] key_pgn [NKEYS];
    logic [2:0]  key_seq [NKEYS];

    fast_packet_reassembler u_dut (.*);

    fpr_checker u_checker (
        .*,
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one item and hold it until the block takes it; start stays high unless a random idle gap drops it.
    task automatic send(logic mode, logic [7:0] src, logic [17:0] pgn, logic [7:0] dst,
                        logic to_all, logic [3:0] len, logic [63:0] data);
        start         <= 1'b1;
        i_mode        <= mode;
        i_source_addr <= src;
        i_pgn         <= pgn;
        i_dest_addr   <= dst;
        i_to_all      <= to_all;
        i_frame_len   <= len;
        i_frame_data  <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (!quiet && $urandom_range(99) < 16) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic tick();
        send(MODE_TICK, 8'($urandom), 18'($urandom), 8'($urandom), 1'($urandom),
             4'($urandom), {$urandom, $urandom});
    endtask

    // Hold the sender until every word has come out and the block has settled.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (words_pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIMEOUT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] first_frame(logic [2:0] seq, logic [7:0] total);
        logic [63:0] d;
        d        = {$urandom, $urandom};
        d[7:0]   = {seq, 5'd0};
        d[15:8]  = total;
        return d;
    endfunction

    function automatic logic [63:0] cont_frame(logic [2:0] seq, logic [4:0] fc);
        logic [63:0] d;
        d      = {$urandom, $urandom};
        d[7:0] = {seq, fc};
        return d;
    endfunction

    // Run one message for a key: first frame then its continuations, with
    // occasional ticks, broken frames and abandoned sessions.
    task automatic run_message(int key);
        logic [7:0]  total;
        logic [2:0]  seq;
        logic [7:0]  dst;
        logic        bcast;
        logic [63:0] d;
        int          nframes, sent_bytes, r;
        r = $urandom_range(99);
        if (r < 4)       total = 8'd255;
        else if (r < 12) total = 8'($urandom_range(49, 254));
        else             total = 8'($urandom_range(1, 48));
        seq   = key_seq[key] + 3'd1;
        key_seq[key] = seq;
        dst   = 8'($urandom);
        bcast = 1'($urandom_range(1));
        send(MODE_FRAME, key_src[key], key_pgn[key], dst, bcast,
             ($urandom_range(9) == 0) ? 4'($urandom_range(2, 15)) : 4'd8,
             first_frame(seq, total));
        sent_bytes = 6;
        nframes    = 1;
        while (sent_bytes < total && nframes < 33) begin
            if ($urandom_range(99) < tick_odds) tick();
            r = $urandom_range(99);
            if (r < 3) return;                              // abandon: session stays open
            d = cont_frame(seq, nframes[4:0]);
            if (r < 6) d[7:5] = ~seq;                       // wrong sequence number
            else if (r < 9) d[4:0] = nframes[4:0] + 5'd1;   // skipped frame
            send(MODE_FRAME, key_src[key], key_pgn[key], 8'($urandom), 1'($urandom),
                 ($urandom_range(9) == 0) ? 4'($urandom_range(1, 15)) : 4'd8, d);
            if (r < 9) return;
            sent_bytes += 7;
            nframes++;
        end
    endtask

    task automatic noise();
        logic [63:0] d;
        d = {$urandom, $urandom};
        if ($urandom_range(1)) d[4:0] = 5'd0;
        send(MODE_FRAME, 8'($urandom), 18'($urandom), 8'($urandom), 1'($urandom),
             4'($urandom), d);
    endtask

    task automatic random_phase(int target);
        while (items_sent < target) begin
            quiet = (items_sent % 100) >= 60 && (items_sent % 100) < 85;
            if ($urandom_range(99) < 15) noise();
            else if ($urandom_range(99) < 10) tick();
            else run_message(int'($urandom_range(NKEYS - 1)));
        end
    endtask

    initial begin
        start         = 1'b0;
        i_mode        = MODE_FRAME;
        i_source_addr = '0;
        i_pgn         = '0;
        i_dest_addr   = '0;
        i_to_all      = 1'b0;
        i_frame_len   = '0;
        i_frame_data  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        quiet         = 1'b0;
        tick_odds     = 5;
        for (int k = 0; k < NKEYS; k++) begin
            key_src[k] = 8'($urandom);
            key_pgn[k] = 18'($urandom);
            key_seq[k] = 3'($urandom);
        end
        key_src[1] = key_src[0];                // same source, different PGN

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored frames, single-frame messages, extremes of the fields.
        tick();
        send(MODE_FRAME, 8'h00, 18'h00000, 8'h00, 1'b0, 4'd0, {8{8'hFF}});       // empty
        send(MODE_FRAME, 8'hFF, 18'h3FFFF, 8'hFF, 1'b1, 4'd1, 64'h0);            // short first
        send(MODE_FRAME, 8'h12, 18'h1F805, 8'h34, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_0000);
        send(MODE_FRAME, 8'hFF, 18'h3FFFF, 8'hA5, 1'b1, 4'd8,
             64'hFFFF_FFFF_FFFF_06E0);                                          // one frame, 6 bytes
        send(MODE_FRAME, 8'h00, 18'h00000, 8'h00, 1'b0, 4'd15,
             64'h8877_6655_4433_0540);                                          // oversized length
        send(MODE_FRAME, 8'h01, 18'h00001, 8'h7F, 1'b0, 4'd3,
             64'h0000_0000_00AB_0100);                                          // one byte message
        send(MODE_FRAME, 8'h55, 18'h2AAAA, 8'h00, 1'b0, 4'd8, 64'h1);            // unknown session
        // Three-frame message, bytes up to frame length 15 on the last.
        send(MODE_FRAME, 8'h20, 18'h1F200, 8'h09, 1'b0, 4'd8, first_frame(3'd2, 8'd20));
        send(MODE_FRAME, 8'h20, 18'h1F200, 8'h00, 1'b0, 4'd8, cont_frame(3'd2, 5'd1));
        send(MODE_FRAME, 8'h20, 18'h1F200, 8'h00, 1'b0, 4'd15, cont_frame(3'd2, 5'd2));
        // Open a session, break it, then its next frame finds nothing.
        send(MODE_FRAME, 8'h21, 18'h1F201, 8'h00, 1'b1, 4'd8, first_frame(3'd7, 8'd30));
        send(MODE_FRAME, 8'h21, 18'h1F201, 8'h00, 1'b1, 4'd8, cont_frame(3'd6, 5'd1));
        send(MODE_FRAME, 8'h21, 18'h1F201, 8'h00, 1'b1, 4'd8, cont_frame(3'd7, 5'd1));
        // Fill the table, then one more first frame is dropped.
        for (int k = 0; k < 9; k++)
            send(MODE_FRAME, 8'h40 + k[7:0], 18'h0EF00, 8'h00, 1'b0, 4'd8,
                 first_frame(3'd1, 8'd40));
        // A short continuation stores one byte in slot 0 and leaves the rest pending.
        send(MODE_FRAME, 8'h40, 18'h0EF00, 8'h00, 1'b0, 4'd2, cont_frame(3'd1, 5'd1));
        drain();

        // Stalls and expiry with the shortest timeout.
        write_timeout(32'd1);
        tick_odds = 30;
        random_phase(90);
        write_timeout(32'hFFFF_FFFF);
        tick_odds = 5;
        random_phase(160);
        write_timeout(32'd12);
        tick_odds = 15;
        random_phase(220);
        write_timeout(fpr_pkg::TIMEOUT_RESET);
        random_phase(260);

        drain();
        if (fail_count == 0 && words_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
